### src/lzw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lzw_pkg
// shared sizes, codes and the dictionary entry layout of the lzw compressor
// ----------------------------------------------------------------------------
package lzw_pkg;

    localparam int DICT_SIZE = 4096;
    localparam int CODE_W    = $clog2(DICT_SIZE);
    localparam int NF_W      = CODE_W + 1;
    localparam int SYM_W     = 5;

    localparam logic [SYM_W-1:0]  LAST_SYMBOL   = SYM_W'(26);
    localparam logic [CODE_W-1:0] FIRST_FREE    = CODE_W'(27);
    localparam logic [NF_W-1:0]   FIRST_FREE_NF = NF_W'(27);
    localparam logic [NF_W-1:0]   DICT_LIMIT    = NF_W'(DICT_SIZE);

    // one learned code: its pair, plus the link to the previous child of the prefix
    typedef struct packed {
        logic [CODE_W-1:0] prefix;
        logic [SYM_W-1:0]  sym;
        logic [CODE_W-1:0] link;
        logic              link_valid;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage : lzw_pkg
`default_nettype wire

### src/lzw_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lzw_ram
// simple dual-port synchronous ram, one write and one registered read port
// ----------------------------------------------------------------------------
module lzw_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 8
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule : lzw_ram
`default_nettype wire

### src/lzw_compressor.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lzw_compressor
// lzw encoder over '#' and A..Z: per-prefix child chains held in two rams
// ----------------------------------------------------------------------------
// an item is done in idle when it opens a message or carries an unused symbol; otherwise the
// head ram is read, then the prefix's child entries are walked (0..27, one ram read each).
// a miss and the end mark each add a state that waits for a free output register.
// a result is in the output register from the cycle after its step and is held until taken.
// after reset a clearing pass writes all 4096 head ram entries, input ready stays low;
// the entry ram is not cleared, stale entries are rejected by a code range and prefix check.
module lzw_compressor (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output      logic                       in_ready,
    input  wire logic [lzw_pkg::SYM_W-1:0]  symbol,
    input  wire logic                       end_of_input,
    output      logic                       out_valid,
    input  wire logic                       out_ready,
    output      logic [lzw_pkg::CODE_W-1:0] out_code,
    output      logic                       final_code
);

    import lzw_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HEAD,
        ST_ENTRY,
        ST_MISS,
        ST_FINAL
    } state_t;

    state_t            state_reg;
    logic [CODE_W-1:0] clr_reg;
    logic [SYM_W-1:0]  sym_reg;
    logic              last_reg;
    logic [CODE_W-1:0] cur_reg;
    logic              have_reg;
    logic [NF_W-1:0]   nf_reg;
    logic [CODE_W-1:0] cand_reg;
    logic [CODE_W-1:0] head_reg;
    logic              head_valid_reg;
    logic              first_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [CODE_W-1:0] out_code_reg;
    logic              out_final_reg;

    logic               accept;
    logic               sym_ok;
    logic               out_free;
    logic               clearing;
    logic               head_re;
    logic               head_we;
    logic [CODE_W-1:0]  head_waddr;
    logic [CODE_W-1:0]  head_wdata;
    logic [CODE_W-1:0]  head_q;
    logic               head_in_range;
    logic               dict_re;
    logic               dict_we;
    logic [CODE_W-1:0]  dict_raddr;
    logic [ENTRY_W-1:0] dict_rdata;
    entry_t             entry;
    entry_t             new_entry;
    logic               prefix_bad;
    logic               hit;
    logic               follow;

    assign in_ready   = (state_reg == ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign out_code   = out_code_reg;
    assign final_code = out_final_reg;

    always_comb
    begin
        accept        = in_valid && in_ready;
        sym_ok        = (symbol <= LAST_SYMBOL);
        out_free      = !out_valid_reg || out_ready;
        clearing      = (state_reg == ST_CLEAR);
        head_re       = accept && sym_ok && have_reg;
        head_in_range = (head_q >= FIRST_FREE) && ({1'b0, head_q} < nf_reg);
        entry         = entry_t'(dict_rdata);
        // the first candidate may be stale, so its prefix must match
        prefix_bad    = first_reg && (entry.prefix != cur_reg);
        hit           = !prefix_bad && (entry.sym == sym_reg);
        follow        = !prefix_bad && !hit && entry.link_valid;
        dict_re       = ((state_reg == ST_HEAD) && head_in_range)
                     || ((state_reg == ST_ENTRY) && follow);
        dict_raddr    = (state_reg == ST_HEAD) ? head_q : entry.link;
        dict_we       = (state_reg == ST_MISS) && out_free && (nf_reg < DICT_LIMIT);
        // heads are cleared to a code below the first learned one
        head_we       = dict_we || clearing;
        head_waddr    = clearing ? clr_reg : cur_reg;
        head_wdata    = clearing ? '0 : nf_reg[CODE_W-1:0];
        new_entry     = '{prefix: cur_reg, sym: sym_reg, link: head_reg,
                          link_valid: head_valid_reg};
        out_valid_next = out_valid_reg && !out_ready;
        if (((state_reg == ST_MISS) || (state_reg == ST_FINAL)) && out_free)
        begin
            out_valid_next = 1'b1;
        end
    end

    lzw_ram #(
        .DEPTH (DICT_SIZE),
        .WIDTH (CODE_W)
    ) u_head_ram (
        .clk   (clk),
        .we    (head_we),
        .waddr (head_waddr),
        .wdata (head_wdata),
        .re    (head_re),
        .raddr (cur_reg),
        .rdata (head_q)
    );

    lzw_ram #(
        .DEPTH (DICT_SIZE),
        .WIDTH (ENTRY_W)
    ) u_entry_ram (
        .clk   (clk),
        .we    (dict_we),
        .waddr (nf_reg[CODE_W-1:0]),
        .wdata (new_entry),
        .re    (dict_re),
        .raddr (dict_raddr),
        .rdata (dict_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_reg        <= '0;
            sym_reg        <= '0;
            last_reg       <= 1'b0;
            cur_reg        <= '0;
            have_reg       <= 1'b0;
            nf_reg         <= FIRST_FREE_NF;
            cand_reg       <= '0;
            head_reg       <= '0;
            head_valid_reg <= 1'b0;
            first_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_code_reg   <= '0;
            out_final_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            case (state_reg)
                ST_CLEAR:
                begin
                    clr_reg <= clr_reg + CODE_W'(1);
                    if (clr_reg == CODE_W'(DICT_SIZE - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        sym_reg  <= symbol;
                        last_reg <= end_of_input;
                        if (sym_ok && have_reg)
                        begin
                            state_reg <= ST_HEAD;
                        end
                        else if (sym_ok)
                        begin
                            // first symbol of a message
                            cur_reg   <= CODE_W'(symbol);
                            have_reg  <= 1'b1;
                            state_reg <= end_of_input ? ST_FINAL : ST_IDLE;
                        end
                        else if (end_of_input)
                        begin
                            if (have_reg)
                            begin
                                state_reg <= ST_FINAL;
                            end
                            else
                            begin
                                cur_reg <= '0;
                                nf_reg  <= FIRST_FREE_NF;
                            end
                        end
                    end
                end
                ST_HEAD:
                begin
                    head_reg       <= head_q;
                    head_valid_reg <= head_in_range;
                    cand_reg       <= head_q;
                    first_reg      <= 1'b1;
                    state_reg      <= head_in_range ? ST_ENTRY : ST_MISS;
                end
                ST_ENTRY:
                begin
                    first_reg <= 1'b0;
                    if (prefix_bad)
                    begin
                        head_valid_reg <= 1'b0;
                        state_reg      <= ST_MISS;
                    end
                    else if (hit)
                    begin
                        cur_reg   <= cand_reg;
                        state_reg <= last_reg ? ST_FINAL : ST_IDLE;
                    end
                    else if (follow)
                    begin
                        cand_reg <= entry.link;
                    end
                    else
                    begin
                        state_reg <= ST_MISS;
                    end
                end
                ST_MISS:
                begin
                    if (out_free)
                    begin
                        out_code_reg  <= cur_reg;
                        out_final_reg <= 1'b0;
                        if (dict_we)
                        begin
                            nf_reg <= nf_reg + NF_W'(1);
                        end
                        cur_reg   <= CODE_W'(sym_reg);
                        state_reg <= last_reg ? ST_FINAL : ST_IDLE;
                    end
                end
                ST_FINAL:
                begin
                    if (out_free)
                    begin
                        out_code_reg  <= cur_reg;
                        out_final_reg <= 1'b1;
                        have_reg      <= 1'b0;
                        cur_reg       <= '0;
                        nf_reg        <= FIRST_FREE_NF;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule : lzw_compressor
`default_nettype wire

### verif/lzw_code_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzw_code_checker
// watches both channels of the lzw compressor, keeps its own copy of the
// dictionary, prefix and free code, and compares every emitted word with the
// code and final flag that the accepted symbols call for
// ----------------------------------------------------------------------------
module lzw_code_checker (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    input  wire logic                       in_ready,
    input  wire logic [lzw_pkg::SYM_W-1:0]  symbol,
    input  wire logic                       end_of_input,
    input  wire logic                       out_valid,
    input  wire logic                       out_ready,
    input  wire logic [lzw_pkg::CODE_W-1:0] out_code,
    input  wire logic                       final_code,
    output int                              errors,
    output int                              pending
);
    import lzw_pkg::*;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              last;
    } code_word_t;

    localparam int REPORT_MAX = 10;

    code_word_t        expected_codes [$];
    // learned pairs, keyed by prefix code and symbol
    logic [CODE_W-1:0] pair_codes [int];
    logic [NF_W-1:0]   free_code;
    logic [CODE_W-1:0] prefix_code;
    logic              prefix_held;

    task automatic encode_word(input logic [SYM_W-1:0] sym, input logic eoi);
        int         key;
        code_word_t w;
        if (sym <= LAST_SYMBOL)
        begin
            if (!prefix_held)
            begin
                prefix_code = CODE_W'(sym);
                prefix_held = 1'b1;
            end
            else
            begin
                key = int'({prefix_code, sym});
                if (pair_codes.exists(key))
                begin
                    prefix_code = pair_codes[key];
                end
                else
                begin
                    w.code = prefix_code;
                    w.last = 1'b0;
                    expected_codes.push_back(w);
                    // table freezes once every code is taken
                    if (free_code < DICT_LIMIT)
                    begin
                        pair_codes[key] = free_code[CODE_W-1:0];
                        free_code       = free_code + NF_W'(1);
                    end
                    prefix_code = CODE_W'(sym);
                end
            end
        end
        if (eoi)
        begin
            if (prefix_held)
            begin
                w.code = prefix_code;
                w.last = 1'b1;
                expected_codes.push_back(w);
            end
            prefix_held = 1'b0;
            prefix_code = '0;
            free_code   = FIRST_FREE_NF;
            pair_codes.delete();
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        code_word_t w;
        if (!rst_n)
        begin
            expected_codes.delete();
            pair_codes.delete();
            free_code   = FIRST_FREE_NF;
            prefix_code = '0;
            prefix_held = 1'b0;
            errors      = 0;
            pending     = 0;
        end
        else
        begin
            if (in_valid && in_ready)
                encode_word(symbol, end_of_input);
            if (out_valid && out_ready)
            begin
                if (expected_codes.size() == 0)
                begin
                    if (errors < REPORT_MAX)
                        $display("%0t: unexpected word: code %0d final %0b",
                                 $realtime, out_code, final_code);
                    errors++;
                end
                else
                begin
                    w = expected_codes.pop_front();
                    if (w.code !== out_code || w.last !== final_code)
                    begin
                        if (errors < REPORT_MAX)
                            $display({"%0t: mismatch: expected code %0d final %0b,",
                                      " got code %0d final %0b"},
                                     $realtime, w.code, w.last, out_code, final_code);
                        errors++;
                    end
                end
            end
            pending = expected_codes.size();
        end
    end

endmodule : lzw_code_checker

### verif/tb_lzw_compressor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lzw_compressor
// drives symbol words into the lzw compressor: directed corner messages, one
// long random message, then random messages under four idling mixes; the
// code checker beside the block judges every output word
// ----------------------------------------------------------------------------
module tb_lzw_compressor;
    import lzw_pkg::*;

    localparam int HALF_PERIOD  = 5;
    localparam int RESET_CYCLES = 5;
    localparam int CYCLE_LIMIT  = 3_000_000;
    localparam int FILL_LEN     = 400;
    localparam int PHASE_ITEMS  = 280;
    localparam int DRAIN_CYCLES = 60;

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              in_valid     = 1'b0;
    logic              in_ready;
    logic [SYM_W-1:0]  symbol       = '0;
    logic              end_of_input = 1'b0;
    logic              out_valid;
    logic              out_ready    = 1'b0;
    logic [CODE_W-1:0] out_code;
    logic              final_code;

    int errors;
    int pending;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int cycle_count    = 0;
    int symbols_sent   = 0;

    lzw_compressor dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .symbol       (symbol),
        .end_of_input (end_of_input),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_code     (out_code),
        .final_code   (final_code)
    );

    lzw_code_checker code_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .symbol       (symbol),
        .end_of_input (end_of_input),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_code     (out_code),
        .final_code   (final_code),
        .errors       (errors),
        .pending      (pending)
    );

    always
    begin
        #(HALF_PERIOD) clk = 1'b1;
        #(HALF_PERIOD) clk = 1'b0;
    end

    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_word(input logic [SYM_W-1:0] s, input logic e);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        symbol       <= s;
        end_of_input <= e;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (s <= LAST_SYMBOL)
            symbols_sent++;
        @(negedge clk);
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    // one message; a narrow alphabet gives long matches
    task automatic send_message(input int len);
        int span;
        int base;
        logic [SYM_W-1:0] s;
        case ($urandom_range(3))
            0: span = 2;
            1: span = 3;
            2: span = 6;
            default: span = 27;
        endcase
        base = $urandom_range(27 - span);
        for (int i = 0; i < len; i++)
        begin
            s = SYM_W'(base + $urandom_range(span - 1));
            if ($urandom_range(99) < 4)
                s = SYM_W'($urandom_range(31, 27));
            if (i == len - 1 && $urandom_range(99) < 15)
                s = SYM_W'($urandom_range(31, 27));
            send_word(s, i == len - 1);
        end
    endtask

    task automatic run_phase(input int sender_pct, input int receiver_pct);
        int  start;
        int  roll;
        int  len;
        bit  paused;
        send_idle_pct  = sender_pct;
        recv_stall_pct = receiver_pct;
        start  = symbols_sent;
        paused = 1'b0;
        while (symbols_sent - start < PHASE_ITEMS)
        begin
            roll = $urandom_range(99);
            if (roll < 5)
            begin
                // end mark on an unused symbol; nothing is held unless a stray word came before
                send_word(SYM_W'($urandom_range(31, 27)), 1'b1);
            end
            else if (roll < 12)
            begin
                send_word(SYM_W'($urandom), 1'($urandom));
            end
            else
            begin
                len = ($urandom_range(9) == 0) ? $urandom_range(120, 30)
                                               : $urandom_range(12, 1);
                send_message(len);
            end
            if (!paused && symbols_sent - start >= PHASE_ITEMS / 2)
            begin
                wait_for_results();
                paused = 1'b1;
            end
        end
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // single-symbol messages at both ends of the alphabet
        send_word(5'd1, 1'b1);
        send_word(5'd0, 1'b1);
        send_word(5'd26, 1'b1);
        // end mark on an unused symbol with nothing held
        send_word(5'd31, 1'b1);
        // repeating pair: hits on learned codes, end on a hit
        send_word(5'd1, 1'b0);
        send_word(5'd2, 1'b0);
        send_word(5'd1, 1'b0);
        send_word(5'd2, 1'b0);
        send_word(5'd1, 1'b0);
        send_word(5'd2, 1'b1);
        // unused symbols inside a message and as its end mark
        send_word(5'd26, 1'b0);
        send_word(5'd27, 1'b0);
        send_word(5'd26, 1'b0);
        send_word(5'd28, 1'b1);
        // end on a miss gives two words
        send_word(5'd0, 1'b0);
        send_word(5'd0, 1'b0);
        send_word(5'd1, 1'b1);
        send_word(5'd1, 1'b0);
        send_word(5'd1, 1'b0);
        send_word(5'd1, 1'b0);
        send_word(5'd1, 1'b1);
        // unused symbol outside a message is ignored
        send_word(5'd30, 1'b0);
        send_word(5'd26, 1'b1);

        // long message over the full alphabet, many prefixes with several children
        for (int i = 0; i < FILL_LEN; i++)
            send_word(SYM_W'($urandom_range(26)), i == FILL_LEN - 1);

        run_phase(0, 0);
        run_phase(60, 0);
        run_phase(0, 60);
        run_phase(30, 30);

        wait_for_results();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (errors == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule : tb_lzw_compressor
